/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the decimal conversion RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define B2DA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define B2DA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/b2da_pkg.sv */
// ---------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
package b2da_pkg;

    localparam int VALUE_W       = 32;
    localparam int FORMAT_W      = 3;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 10;
    localparam int BITS_PER_STEP = 4;
    localparam int NUM_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(NUM_STEPS);
    localparam int POS_W         = $clog2(NUM_DIGITS);

    // Format codes
    localparam logic [FORMAT_W-1:0] FMT_U32 = 3'd0;
    localparam logic [FORMAT_W-1:0] FMT_S32 = 3'd1;
    localparam logic [FORMAT_W-1:0] FMT_U16 = 3'd2;
    localparam logic [FORMAT_W-1:0] FMT_S16 = 3'd3;
    localparam logic [FORMAT_W-1:0] FMT_U8  = 3'd4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // Index of the leading digit for the fixed five-digit forms
    localparam logic [POS_W-1:0] FIXED_START = 4'd4;

    typedef logic [DIGIT_W-1:0] digit_t;

    // Converted value handed from the cell row to the emitter
    typedef struct packed {
        logic                        neg;
        logic [POS_W-1:0]            start;
        digit_t [NUM_DIGITS-1:0]     digits;
    } b2da_xfer_t;

endpackage

/* sv/b2da_cell.sv */
// ---------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the shift-and-add-3 row; takes four bits per cycle while shift_en is high.
// ---------------------------------------------------------------------------
module b2da_cell import b2da_pkg::*; (
    input  logic                     aclk,
    input  logic                     clear,
    input  logic                     shift_en,
    input  logic [BITS_PER_STEP-1:0] carry_in,
    output digit_t                   digit,
    output logic [BITS_PER_STEP-1:0] carry_out
);

    digit_t digit_reg;
    digit_t digit_next;

    // Four correct-then-shift steps; bit s of carry_in enters at step s.
    always_comb begin
        digit_t d;
        d = digit_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            if (d >= digit_t'(5)) begin
                d = digit_t'(d + digit_t'(3));
            end
            carry_out[s] = d[DIGIT_W-1];
            d = {d[DIGIT_W-2:0], carry_in[s]};
        end
        digit_next = d;
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            digit_reg <= '0;
        end else if (shift_en) begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

/* sv/b2da_emit.sv */
// ---------------------------------------------------------------------------
// b2da_emit
// Character emitter: holds one converted value and walks its digits out.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module b2da_emit import b2da_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  b2da_xfer_t        xfer,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_character,
    output logic              m_last
);

    logic                         valid_reg, valid_next;
    logic                         neg_reg, neg_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    digit_t [NUM_DIGITS-1:0]      digits_reg;
    digit_t                       cur_digit;
    logic                         fire;

    assign cur_digit   = digits_reg[pos_reg];
    assign m_valid     = valid_reg;
    assign m_last      = !neg_reg && (pos_reg == '0);
    assign m_character = neg_reg ? ASCII_MINUS
                                 : CHAR_W'(ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit});
    assign fire        = valid_reg && m_ready;
    assign free        = !valid_reg || (fire && m_last);

    always_comb begin
        valid_next = valid_reg;
        neg_next   = neg_reg;
        pos_next   = pos_reg;
        if (load) begin
            valid_next = 1'b1;
            neg_next   = xfer.neg;
            pos_next   = xfer.start;
        end else if (fire) begin
            if (neg_reg) begin
                neg_next = 1'b0;
            end else if (pos_reg == '0) begin
                valid_next = 1'b0;
            end else begin
                pos_next = pos_reg - POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            neg_reg   <= 1'b0;
            pos_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            neg_reg   <= neg_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            digits_reg <= xfer.digits;
        end
    end

    `B2DA_ASSERT(a_load_when_free, aclk, aresetn, !load || free, "load while emitter busy")
    `B2DA_ASSERT_NEXT(a_drain_on_last, aclk, aresetn, fire && m_last && !load, !valid_reg, "emitter kept valid after last")
    `B2DA_ASSERT(a_pos_in_range, aclk, aresetn, !valid_reg || (pos_reg < POS_W'(NUM_DIGITS)), "digit pointer out of range")

endmodule

/* sv/binary_to_decimal_ascii.sv */
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// Spells a 32/16/8-bit value, signed or unsigned, as decimal ASCII text.
// ---------------------------------------------------------------------------
//  Channel | Direction | Ports                                 | Per transaction
//  --------+-----------+---------------------------------------+-----------------------
//  s_      | in        | s_valid s_ready s_value s_format      | one value and format
//  m_      | out       | m_valid m_ready m_character m_last    | one ASCII character
//
//  Conversion runs in a row of ten BCD cells, four value bits per cycle; the
//  full 32-bit value shifts through the cell row for every format.
//  The emitter then gives 1 to 11 characters, one per cycle while m_ready
//  is high; conversion of the next value overlaps emission of the current
//  one. Unused format codes are accepted and dropped.
//  Reset (aresetn low, synchronous) empties both the converter and emitter.
//  A stall on m_ready holds the current character and backs up to s_ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_to_decimal_ascii import b2da_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic [FORMAT_W-1:0] s_format,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_character,
    output logic                m_last
);

    // Converter control
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic                  neg_reg;
    logic                  fixed_reg;
    logic [VALUE_W-1:0]    bin_reg;

    logic                  s_fire;
    logic                  fmt_ok;
    logic                  in_neg;
    logic [VALUE_W-1:0]    in_mag;
    logic                  start_conv;
    logic                  xfer_go;
    logic                  emit_free;

    // Cell row
    logic [BITS_PER_STEP-1:0] carry [NUM_DIGITS+1];
    digit_t [NUM_DIGITS-1:0]  digits;
    b2da_xfer_t               xfer;

    assign s_fire = s_valid && s_ready;

    // Accept when the converter is empty, or when its result leaves this cycle.
    assign s_ready = !busy_reg && (!done_reg || xfer_go);
    assign xfer_go = done_reg && emit_free;

    // Decode format: pick magnitude and sign
    always_comb begin
        fmt_ok = 1'b1;
        in_neg = 1'b0;
        in_mag = s_value;
        case (s_format)
            FMT_U32: begin
                in_mag = s_value;
            end
            FMT_S32: begin
                in_neg = s_value[VALUE_W-1];
                in_mag = in_neg ? VALUE_W'(~s_value + VALUE_W'(1)) : s_value;
            end
            FMT_U16: begin
                in_mag = {16'h0, s_value[15:0]};
            end
            FMT_S16: begin
                in_neg = s_value[15];
                in_mag = {16'h0, (in_neg ? 16'(~s_value[15:0] + 16'd1) : s_value[15:0])};
            end
            FMT_U8: begin
                in_mag = {24'h0, s_value[7:0]};
            end
            default: begin
                fmt_ok = 1'b0;
            end
        endcase
    end

    assign start_conv = s_fire && fmt_ok;

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        if (xfer_go) begin
            done_next = 1'b0;
        end
        if (start_conv) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            step_next = STEP_CNT_W'(step_reg + STEP_CNT_W'(1));
            if (step_reg == STEP_CNT_W'(NUM_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Load the magnitude on start; advance four bits per busy cycle.
    always_ff @(posedge aclk) begin
        if (start_conv) begin
            bin_reg   <= in_mag;
            neg_reg   <= in_neg;
            fixed_reg <= s_format inside {FMT_U16, FMT_S16};
        end else if (busy_reg) begin
            bin_reg <= {bin_reg[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
        end
    end

    // Most significant value bit enters the row first.
    always_comb begin
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            carry[0][s] = bin_reg[VALUE_W-1-s];
        end
    end

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        b2da_cell u_cell (
            .aclk      (aclk),
            .clear     (start_conv),
            .shift_en  (busy_reg),
            .carry_in  (carry[g]),
            .digit     (digits[g]),
            .carry_out (carry[g+1])
        );
    end

    // Leading digit position: highest nonzero digit, or fixed for 16-bit forms.
    always_comb begin
        xfer.neg    = neg_reg;
        xfer.digits = digits;
        xfer.start  = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (digits[k] != '0) begin
                xfer.start = POS_W'(k);
            end
        end
        if (fixed_reg) begin
            xfer.start = FIXED_START;
        end
    end

    b2da_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (xfer_go),
        .xfer        (xfer),
        .free        (emit_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    `B2DA_ASSERT(a_no_overflow, aclk, aresetn, !busy_reg || (carry[NUM_DIGITS] == '0), "carry out of top digit cell")
    `B2DA_ASSERT(a_busy_done_excl, aclk, aresetn, !(busy_reg && done_reg), "converter busy and done together")
    `B2DA_ASSERT_NEXT(a_start_busy, aclk, aresetn, start_conv, busy_reg && (step_reg == '0), "conversion did not start")

endmodule
